/* hw/rtl/tga_rle_pkg.sv */
package tga_rle_pkg;

    // Default palette size
    localparam int PALETTE_DEPTH_DEF = 256;

    // Field widths
    localparam int KIND_W  = 2;
    localparam int BYTE_W  = 8;
    localparam int COLOR_W = 24;
    localparam int COUNT_W = 32;
    localparam int CFG_IDX_W = 2;

    // Request kinds
    localparam logic [KIND_W-1:0] KIND_PIXEL     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PALETTE   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_NEW_IMAGE = 2'd2;
    localparam logic [KIND_W-1:0] KIND_RESERVED  = 2'd3;

    // Pixel formats
    localparam logic [1:0] FMT_INDEXED  = 2'd0;
    localparam logic [1:0] FMT_BGR24    = 2'd1;
    localparam logic [1:0] FMT_BGRA32   = 2'd2;
    localparam logic [1:0] FMT_RESERVED = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RLE_ENABLED  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_FORMAT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_TOTAL  = 2'd2;

    localparam logic [BYTE_W-1:0] ALPHA_OPAQUE = 8'hFF;

    // Palette write port
    typedef struct packed {
        logic               en;
        logic [BYTE_W-1:0]  addr;
        logic [COLOR_W-1:0] color;
    } pal_wr_t;

    // Palette lookup port
    typedef struct packed {
        logic              en;
        logic [BYTE_W-1:0] addr;
    } pal_rd_t;

endpackage

/* hw/rtl/tga_rle_palette.sv */
// Colour palette: one write and one registered read per cycle.
// Entries never written read as zero through per-entry valid bits.
module tga_rle_palette
    import tga_rle_pkg::*;
#(
    parameter int DEPTH = PALETTE_DEPTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  pal_wr_t            wr,
    input  pal_rd_t            rd,
    output logic [COLOR_W-1:0] rd_color
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [COLOR_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]   valid_reg;
    logic [COLOR_W-1:0] rd_data_reg;
    logic               rd_hit_reg;
    logic               wr_in_range;
    logic               rd_in_range;

    // Indexes at or above the depth are out of range
    assign wr_in_range = ({1'b0, wr.addr} < 9'(DEPTH));
    assign rd_in_range = ({1'b0, rd.addr} < 9'(DEPTH));

    // Storage
    always_ff @(posedge clk)
    begin
        if (wr.en && wr_in_range)
        begin
            mem[wr.addr[IDX_W-1:0]] <= wr.color;
        end
        if (rd.en)
        begin
            rd_data_reg <= mem[rd.addr[IDX_W-1:0]];
        end
    end

    // Written marks and read hit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_hit_reg <= 1'b0;
        end
        else
        begin
            if (wr.en && wr_in_range)
            begin
                valid_reg[wr.addr[IDX_W-1:0]] <= 1'b1;
            end
            if (rd.en)
            begin
                rd_hit_reg <= rd_in_range && valid_reg[rd.addr[IDX_W-1:0]];
            end
        end
    end

    assign rd_color = rd_hit_reg ? rd_data_reg : '0;

endmodule

/* hw/rtl/tga_pixel_rle_decoder.sv */
// TGA pixel stream decoder. Takes one request per clock (a pixel data byte,
// a palette write or a new-image start) and turns the pixel bytes of 8-bit
// indexed, 24-bit BGR or 32-bit BGRA images, raw or run-length packed, into
// RGBA pixels. Each request is decoded in the cycle it is accepted and its
// pixel, if any, appears on the output register in the next cycle; a run packet
// gives a single pixel with its repeat count clipped to the pixels left in the
// image. Sustained rate is one request per clock; in_ready only drops while
// the output register holds a pixel that out_ready has not taken, and the
// indexed-colour lookup is one synchronous read of the palette memory. The
// palette reads as all zero after reset without a clearing pass. The pixel
// that completes the image carries last_pixel; later data bytes are dropped
// until a new-image request. Configuration writes take effect at once and are
// to be made only while no request is in flight.
module tga_pixel_rle_decoder
    import tga_rle_pkg::*;
#(
    parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // Request channel
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [KIND_W-1:0]    kind,
    input  logic [BYTE_W-1:0]    data_byte,
    input  logic [BYTE_W-1:0]    palette_index,
    input  logic [COLOR_W-1:0]   palette_color,
    // Pixel channel
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [BYTE_W-1:0]    color_index,
    output logic [BYTE_W-1:0]    red,
    output logic [BYTE_W-1:0]    green,
    output logic [BYTE_W-1:0]    blue,
    output logic [BYTE_W-1:0]    alpha,
    output logic [BYTE_W-1:0]    repeat_res,
    output logic                 last_pixel,
    // Configuration
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COUNT_W-1:0]   cfg_data
);

    // Configuration
    logic               rle_enabled_reg,  rle_enabled_next;
    logic [1:0]         pixel_format_reg, pixel_format_next;
    logic [COUNT_W-1:0] pixel_total_reg,  pixel_total_next;

    // Decode state
    logic [7:0]         packet_left_reg,    packet_left_next;
    logic               packet_is_run_reg,  packet_is_run_next;
    logic [1:0]         byte_position_reg,  byte_position_next;
    logic [COLOR_W-1:0] partial_color_reg,  partial_color_next;
    logic [COUNT_W-1:0] pixels_done_reg,    pixels_done_next;
    logic [COUNT_W-1:0] pixels_left_reg,    pixels_left_next;
    logic               exhausted_reg,      exhausted_next;
    logic               image_complete_reg, image_complete_next;

    // Output stage
    logic               out_valid_reg;
    logic               use_palette_reg,  use_palette_next;
    logic [BYTE_W-1:0]  color_index_reg,  color_index_next;
    logic [BYTE_W-1:0]  red_reg,          red_next;
    logic [BYTE_W-1:0]  green_reg,        green_next;
    logic [BYTE_W-1:0]  blue_reg,         blue_next;
    logic [BYTE_W-1:0]  alpha_reg,        alpha_next;
    logic [BYTE_W-1:0]  repeat_reg,       repeat_next;
    logic               last_reg,         last_next;

    logic               accept;
    logic               emit;
    logic               pixel_last_byte;
    logic [7:0]         run_count;
    logic               complete;
    pal_wr_t            pal_wr;
    pal_rd_t            pal_rd;
    logic [COLOR_W-1:0] pal_color;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // Last byte of a pixel for the current format
    always_comb
    begin
        unique case (pixel_format_reg)
            FMT_INDEXED: pixel_last_byte = 1'b1;
            FMT_BGR24:   pixel_last_byte = (byte_position_reg >= 2'd2);
            FMT_BGRA32:  pixel_last_byte = (byte_position_reg == 2'd3);
            default:     pixel_last_byte = 1'b0;
        endcase
    end

    // Run length clipped to the pixels left
    assign run_count = ((pixels_left_reg[COUNT_W-1:8] != '0)
                        || (pixels_left_reg[7:0] >= packet_left_reg))
                       ? packet_left_reg : pixels_left_reg[7:0];

    // Request decode and configuration
    always_comb
    begin
        rle_enabled_next    = rle_enabled_reg;
        pixel_format_next   = pixel_format_reg;
        pixel_total_next    = pixel_total_reg;
        packet_left_next    = packet_left_reg;
        packet_is_run_next  = packet_is_run_reg;
        byte_position_next  = byte_position_reg;
        partial_color_next  = partial_color_reg;
        pixels_done_next    = pixels_done_reg;
        pixels_left_next    = pixels_left_reg;
        exhausted_next      = exhausted_reg;
        image_complete_next = image_complete_reg;

        emit             = 1'b0;
        use_palette_next = 1'b0;
        color_index_next = '0;
        red_next         = '0;
        green_next       = '0;
        blue_next        = '0;
        alpha_next       = ALPHA_OPAQUE;
        repeat_next      = 8'd1;
        last_next        = 1'b0;
        complete         = 1'b0;

        pal_wr.en    = 1'b0;
        pal_wr.addr  = palette_index;
        pal_wr.color = palette_color;
        pal_rd.en    = 1'b0;
        pal_rd.addr  = data_byte;

        if (accept)
        begin
            // Reserved kinds and dropped data bytes fall through untouched
            if (kind == KIND_PALETTE)
            begin
                pal_wr.en = 1'b1;
            end
            else if (kind == KIND_NEW_IMAGE)
            begin
                packet_left_next    = '0;
                packet_is_run_next  = 1'b0;
                byte_position_next  = '0;
                partial_color_next  = '0;
                pixels_done_next    = '0;
                pixels_left_next    = pixel_total_reg;
                exhausted_next      = (pixel_total_reg == '0);
                image_complete_next = 1'b0;
            end
            else if (kind == KIND_PIXEL && pixel_format_reg != FMT_RESERVED
                     && !image_complete_reg && !exhausted_reg)
            begin
                priority if (rle_enabled_reg && packet_left_reg == '0)
                begin
                    // Packet header
                    packet_is_run_next = data_byte[7];
                    packet_left_next   = {1'b0, data_byte[6:0]} + 8'd1;
                    byte_position_next = '0;
                end
                else if (!pixel_last_byte)
                begin
                    // Collect blue, green, red in turn
                    unique case (byte_position_reg)
                        2'd0:    partial_color_next[23:16] = data_byte;
                        2'd1:    partial_color_next[15:8]  = data_byte;
                        2'd2:    partial_color_next[7:0]   = data_byte;
                        default: partial_color_next        = partial_color_reg;
                    endcase
                    byte_position_next = byte_position_reg + 2'd1;
                end
                else
                begin
                    // Pixel complete
                    emit = 1'b1;
                    unique case (pixel_format_reg)
                        FMT_INDEXED:
                        begin
                            use_palette_next = 1'b1;
                            color_index_next = data_byte;
                            pal_rd.en        = 1'b1;
                        end
                        FMT_BGR24:
                        begin
                            blue_next  = partial_color_reg[23:16];
                            green_next = partial_color_reg[15:8];
                            red_next   = data_byte;
                        end
                        default:
                        begin
                            blue_next  = partial_color_reg[23:16];
                            green_next = partial_color_reg[15:8];
                            red_next   = partial_color_reg[7:0];
                            alpha_next = data_byte;
                        end
                    endcase

                    if (rle_enabled_reg && packet_is_run_reg)
                    begin
                        repeat_next      = run_count;
                        packet_left_next = '0;
                    end
                    else if (rle_enabled_reg)
                    begin
                        packet_left_next = packet_left_reg - 8'd1;
                    end

                    // Repeat never exceeds the pixels left
                    complete            = (COUNT_W'(repeat_next) == pixels_left_reg);
                    pixels_done_next    = pixels_done_reg + COUNT_W'(repeat_next);
                    pixels_left_next    = pixels_left_reg - COUNT_W'(repeat_next);
                    exhausted_next      = complete;
                    image_complete_next = complete;
                    last_next           = complete;
                    byte_position_next  = '0;
                    partial_color_next  = '0;
                end
            end
        end

        if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_RLE_ENABLED:  rle_enabled_next  = cfg_data[0];
                CFG_PIXEL_FORMAT: pixel_format_next = cfg_data[1:0];
                CFG_PIXEL_TOTAL:
                begin
                    pixel_total_next = cfg_data;
                    pixels_left_next = cfg_data - pixels_done_reg;
                    exhausted_next   = (cfg_data <= pixels_done_reg);
                end
                default: rle_enabled_next = rle_enabled_reg;
            endcase
        end
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rle_enabled_reg    <= 1'b0;
            pixel_format_reg   <= FMT_INDEXED;
            pixel_total_reg    <= COUNT_W'(1);
            packet_left_reg    <= '0;
            packet_is_run_reg  <= 1'b0;
            byte_position_reg  <= '0;
            partial_color_reg  <= '0;
            pixels_done_reg    <= '0;
            pixels_left_reg    <= COUNT_W'(1);
            exhausted_reg      <= 1'b0;
            image_complete_reg <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            rle_enabled_reg    <= rle_enabled_next;
            pixel_format_reg   <= pixel_format_next;
            pixel_total_reg    <= pixel_total_next;
            packet_left_reg    <= packet_left_next;
            packet_is_run_reg  <= packet_is_run_next;
            byte_position_reg  <= byte_position_next;
            partial_color_reg  <= partial_color_next;
            pixels_done_reg    <= pixels_done_next;
            pixels_left_reg    <= pixels_left_next;
            exhausted_reg      <= exhausted_next;
            image_complete_reg <= image_complete_next;
            if (accept)
            begin
                out_valid_reg <= emit;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            use_palette_reg <= use_palette_next;
            color_index_reg <= color_index_next;
            red_reg         <= red_next;
            green_reg       <= green_next;
            blue_reg        <= blue_next;
            alpha_reg       <= alpha_next;
            repeat_reg      <= repeat_next;
            last_reg        <= last_next;
        end
    end

    tga_rle_palette #(
        .DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (pal_wr),
        .rd       (pal_rd),
        .rd_color (pal_color)
    );

    // Indexed pixels take their colour from the palette read
    assign out_valid   = out_valid_reg;
    assign color_index = color_index_reg;
    assign red         = use_palette_reg ? pal_color[7:0]   : red_reg;
    assign green       = use_palette_reg ? pal_color[15:8]  : green_reg;
    assign blue        = use_palette_reg ? pal_color[23:16] : blue_reg;
    assign alpha       = alpha_reg;
    assign repeat_res  = repeat_reg;
    assign last_pixel  = last_reg;

endmodule

/* hw/rtl/tga_rle_checker.sv */
// Port-level checks for the pixel decoder
module tga_rle_checker
    import tga_rle_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic [BYTE_W-1:0]    color_index,
    input logic [BYTE_W-1:0]    red,
    input logic [BYTE_W-1:0]    green,
    input logic [BYTE_W-1:0]    blue,
    input logic [BYTE_W-1:0]    alpha,
    input logic [BYTE_W-1:0]    repeat_res,
    input logic                 last_pixel
);

    // A stalled pixel holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid
            && $stable({color_index, red, green, blue, alpha, repeat_res, last_pixel}))
        else $error("pixel changed while stalled");

    // No new request while the output is stalled
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("request taken over a stalled pixel");

    // An empty output register never blocks input
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty output");

    // Repeat count stays within one run packet
    a_repeat_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (repeat_res != 8'd0) && (repeat_res <= 8'd128))
        else $error("repeat count out of range");

    // Nothing follows the last pixel straight away
    a_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && last_pixel |=> !out_valid)
        else $error("pixel right after the last pixel");

endmodule

bind tga_pixel_rle_decoder tga_rle_checker u_checker (.*);
